FILE: rtl/core/ncc_pkg.sv
// Package: shared types and constants of the correlation score block.
`timescale 1ns / 1ps
package ncc_pkg;

    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned SUM_W    = 24;
    localparam int unsigned SQSUM_W  = 33;
    localparam int unsigned WIDE_W   = 128;
    localparam int unsigned MULB_W   = 64;

    localparam logic [COUNT_W-1:0] MAX_PIXELS = 17'd65536;
    localparam logic [MULB_W-1:0]  THRESH_SCALE = 64'd1000000;
    localparam logic [15:0]        SCORE_MAX  = 16'd32767;
    localparam logic [15:0]        SEARCH_TOP = 16'd32768;

    // one finished area's sums
    typedef struct packed {
        logic [COUNT_W-1:0] n;
        logic [SUM_W-1:0]   st;
        logic [SQSUM_W-1:0] st2;
        logic [SUM_W-1:0]   si;
        logic [SQSUM_W-1:0] si2;
        logic [SQSUM_W-1:0] sti;
    } area_sums_t;

    typedef struct packed {
        logic              start;
        logic [WIDE_W-1:0] a;
        logic [MULB_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              busy;
        logic [WIDE_W-1:0] product;
    } mul_rsp_t;

endpackage

FILE: rtl/core/ncc_if.sv
// Interfaces: pixel pair channel and score channel.
`timescale 1ns / 1ps
interface ncc_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] template_pixel;
    logic [7:0] image_pixel;
    logic       x_odd;
    logic       y_odd;
    logic       last_pixel;

    modport source (output valid, template_pixel, image_pixel, x_odd, y_odd, last_pixel,
                    input ready);
    modport sink   (input valid, template_pixel, image_pixel, x_odd, y_odd, last_pixel,
                    output ready);
endinterface

interface ncc_score_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] correlation;
    logic [16:0]        pixels_used;

    modport source (output valid, correlation, pixels_used, input ready);
    modport sink   (input valid, correlation, pixels_used, output ready);
endinterface

FILE: rtl/core/normalized_cross_correlation_score.sv
// Top level: normalized cross-correlation score, Q1.15.
//
//  channel    dir  handshake     payload
//  pixel_in   in   valid/ready   template_pixel, image_pixel, x_odd, y_odd, last_pixel
//  score_out  out  valid/ready   correlation, pixels_used
//  cfg        in   cfg_wr_en     cfg_wr_data = subsample_enable
//
// Pixel requests are taken one per clock; each area's sums go into a two-entry queue.
// The score is worked out by a bit-serial multiplier shared by all products and a bisection
// of up to 16 steps for the root; an empty area skips both, and flat data ends before the
// search.
// pixel_in stalls only when the queue holds two areas awaiting a score.
// Reset clears the sums, the queue, the sequencer and subsample_enable.
`timescale 1ns / 1ps
module normalized_cross_correlation_score (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    ncc_pixel_if.sink   pixel_in,
    ncc_score_if.source score_out
);

    logic                push;
    ncc_pkg::area_sums_t push_data;
    logic                q_not_full;
    logic                q_not_empty;
    logic                pop;
    ncc_pkg::area_sums_t pop_data;
    ncc_pkg::mul_req_t   mul_req;
    ncc_pkg::mul_rsp_t   mul_rsp;

    assign pixel_in.ready = q_not_full;

    ncc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .template_pixel (pixel_in.template_pixel),
        .image_pixel    (pixel_in.image_pixel),
        .x_odd          (pixel_in.x_odd),
        .y_odd          (pixel_in.y_odd),
        .last_pixel     (pixel_in.last_pixel),
        .accept         (pixel_in.valid && q_not_full),
        .push           (push),
        .push_data      (push_data)
    );

    ncc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .not_full  (q_not_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .pop_data  (pop_data)
    );

    ncc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    ncc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (q_not_empty),
        .job_data    (pop_data),
        .job_pop     (pop),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp),
        .out_valid   (score_out.valid),
        .out_ready   (score_out.ready),
        .correlation (score_out.correlation),
        .pixels_used (score_out.pixels_used)
    );

endmodule

FILE: rtl/core/ncc_front.sv
// Front end: pixel qualification and running sums, one request per clock.
`timescale 1ns / 1ps
module ncc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic [7:0]          template_pixel,
    input  logic [7:0]          image_pixel,
    input  logic                x_odd,
    input  logic                y_odd,
    input  logic                last_pixel,
    input  logic                accept,
    output logic                push,
    output ncc_pkg::area_sums_t push_data
);

    logic                subsample_reg;
    ncc_pkg::area_sums_t sums_reg;
    ncc_pkg::area_sums_t sums_next;
    logic                take;

    always_comb
    begin
        take = (!subsample_reg || (!x_odd && !y_odd)) && (sums_reg.n < ncc_pkg::MAX_PIXELS);
        sums_next = sums_reg;
        if (take)
        begin
            sums_next.n   = sums_reg.n + 17'd1;
            sums_next.st  = sums_reg.st + 24'(template_pixel);
            sums_next.si  = sums_reg.si + 24'(image_pixel);
            sums_next.st2 = sums_reg.st2 + 33'(16'(template_pixel) * 16'(template_pixel));
            sums_next.si2 = sums_reg.si2 + 33'(16'(image_pixel) * 16'(image_pixel));
            sums_next.sti = sums_reg.sti + 33'(16'(template_pixel) * 16'(image_pixel));
        end
    end

    assign push      = accept && last_pixel;
    assign push_data = sums_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subsample_reg <= 1'b0;
            sums_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                subsample_reg <= cfg_wr_data;
            if (accept)
                sums_reg <= last_pixel ? '0 : sums_next;
        end
    end

endmodule

FILE: rtl/core/ncc_queue.sv
// Two-entry queue of finished area sums between front and back.
`timescale 1ns / 1ps
module ncc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ncc_pkg::area_sums_t push_data,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output ncc_pkg::area_sums_t pop_data
);

    ncc_pkg::area_sums_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not advance");
`endif

endmodule

FILE: rtl/core/ncc_mul.sv
// Shift-add multiplier: one multiplier bit per cycle, 128-bit product.
`timescale 1ns / 1ps
module ncc_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  ncc_pkg::mul_req_t req,
    output ncc_pkg::mul_rsp_t rsp
);

    logic                       busy_reg;
    logic [ncc_pkg::WIDE_W-1:0] acc_reg;
    logic [ncc_pkg::WIDE_W-1:0] a_reg;
    logic [ncc_pkg::MULB_W-1:0] b_reg;

    assign rsp.busy    = busy_reg;
    assign rsp.product = acc_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= '0;
            a_reg   <= req.a;
            b_reg   <= req.b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    // finishes as soon as the remaining multiplier bits are zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (req.start)
            busy_reg <= 1'b1;
        else if (busy_reg && (b_reg == '0))
            busy_reg <= 1'b0;
    end

endmodule

FILE: rtl/core/ncc_back.sv
// Back end: variance, threshold test and bisection search for the score.
`timescale 1ns / 1ps
module ncc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  ncc_pkg::area_sums_t job_data,
    output logic                job_pop,
    output ncc_pkg::mul_req_t   mul_req,
    input  ncc_pkg::mul_rsp_t   mul_rsp,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  correlation,
    output logic [16:0]         pixels_used
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_TA, S_TB, S_IA, S_IB, S_P, S_L, S_R,
        S_CA, S_CB, S_C2, S_SEARCH, S_T1, S_T2, S_OUT
    } state_t;

    state_t                     state_reg;
    logic                       issued_reg;
    ncc_pkg::area_sums_t        job_reg;
    logic [ncc_pkg::WIDE_W-1:0] tmp_reg;
    logic [ncc_pkg::MULB_W-1:0] vt_reg;
    logic [ncc_pkg::MULB_W-1:0] vi_reg;
    logic [ncc_pkg::MULB_W-1:0] cmag_reg;
    logic [ncc_pkg::WIDE_W-1:0] p_reg;
    logic [ncc_pkg::WIDE_W-1:0] c2_reg;
    logic                       neg_reg;
    logic [15:0]                lo_reg;
    logic [15:0]                hi_reg;
    logic [15:0]                score_reg;
    logic                       out_valid_reg;
    logic signed [15:0]         corr_reg;
    logic [16:0]                used_reg;

    logic                       mul_state;
    logic                       mul_done;
    logic [16:0]                mid_sum;
    logic [15:0]                mid;
    logic [16:0]                odd_full;
    logic [15:0]                odd;
    logic [ncc_pkg::WIDE_W-1:0] diff;

    assign mid_sum  = 17'(lo_reg) + 17'(hi_reg) + 17'd1;
    assign mid      = mid_sum[16:1];
    assign odd_full = {mid, 1'b0} - 17'd1;
    assign odd      = odd_full[15:0];
    assign diff     = tmp_reg - mul_rsp.product;
    assign mul_done = issued_reg && !mul_rsp.busy;

    always_comb
    begin
        mul_state = 1'b1;
        mul_req.a = '0;
        mul_req.b = '0;
        unique case (state_reg)
            S_TA: begin mul_req.a = 128'(job_reg.st2); mul_req.b = 64'(job_reg.n); end
            S_TB: begin mul_req.a = 128'(job_reg.st);  mul_req.b = 64'(job_reg.st); end
            S_IA: begin mul_req.a = 128'(job_reg.si2); mul_req.b = 64'(job_reg.n); end
            S_IB: begin mul_req.a = 128'(job_reg.si);  mul_req.b = 64'(job_reg.si); end
            S_P:  begin mul_req.a = 128'(vt_reg);      mul_req.b = vi_reg; end
            S_L:  begin mul_req.a = p_reg;             mul_req.b = ncc_pkg::THRESH_SCALE; end
            S_R:  begin mul_req.a = 128'(job_reg.n);   mul_req.b = 64'(job_reg.n); end
            S_CA: begin mul_req.a = 128'(job_reg.sti); mul_req.b = 64'(job_reg.n); end
            S_CB: begin mul_req.a = 128'(job_reg.st);  mul_req.b = 64'(job_reg.si); end
            S_C2: begin mul_req.a = 128'(cmag_reg);    mul_req.b = cmag_reg; end
            S_T1: begin mul_req.a = p_reg;             mul_req.b = 64'(odd); end
            S_T2: begin mul_req.a = tmp_reg;           mul_req.b = 64'(odd); end
            default: mul_state = 1'b0;
        endcase
        mul_req.start = mul_state && !issued_reg;
    end

    assign job_pop     = (state_reg == S_IDLE) && job_valid;
    assign out_valid   = out_valid_reg;
    assign correlation = corr_reg;
    assign pixels_used = used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // in S_OUT the output register is handled by the state itself
            if (out_valid_reg && out_ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;
            if (mul_req.start)
                issued_reg <= 1'b1;
            if (mul_done)
                issued_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job_data;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    score_reg <= '0;
                    state_reg <= (job_reg.n == '0) ? S_OUT : S_TA;
                end
                S_TA: if (mul_done) begin tmp_reg <= mul_rsp.product; state_reg <= S_TB; end
                S_TB:
                begin
                    if (mul_done)
                    begin
                        vt_reg    <= (tmp_reg >= mul_rsp.product) ? diff[63:0] : '0;
                        state_reg <= S_IA;
                    end
                end
                S_IA: if (mul_done) begin tmp_reg <= mul_rsp.product; state_reg <= S_IB; end
                S_IB:
                begin
                    if (mul_done)
                    begin
                        vi_reg    <= (tmp_reg >= mul_rsp.product) ? diff[63:0] : '0;
                        state_reg <= S_P;
                    end
                end
                S_P:  if (mul_done) begin p_reg <= mul_rsp.product; state_reg <= S_L; end
                S_L:  if (mul_done) begin tmp_reg <= mul_rsp.product; state_reg <= S_R; end
                S_R:
                begin
                    // flat data: scaled variance product under n squared
                    if (mul_done)
                        state_reg <= (tmp_reg < mul_rsp.product) ? S_OUT : S_CA;
                end
                S_CA: if (mul_done) begin tmp_reg <= mul_rsp.product; state_reg <= S_CB; end
                S_CB:
                begin
                    if (mul_done)
                    begin
                        neg_reg   <= tmp_reg < mul_rsp.product;
                        cmag_reg  <= (tmp_reg < mul_rsp.product)
                                     ? 64'(mul_rsp.product - tmp_reg) : diff[63:0];
                        lo_reg    <= '0;
                        hi_reg    <= ncc_pkg::SEARCH_TOP;
                        state_reg <= S_C2;
                    end
                end
                S_C2: if (mul_done) begin c2_reg <= mul_rsp.product << 32; state_reg <= S_SEARCH; end
                S_SEARCH:
                begin
                    if (lo_reg < hi_reg)
                        state_reg <= S_T1;
                    else
                    begin
                        if (neg_reg)
                            score_reg <= 16'd0 - lo_reg;
                        else
                            score_reg <= (lo_reg > ncc_pkg::SCORE_MAX) ? ncc_pkg::SCORE_MAX
                                                                        : lo_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_T1: if (mul_done) begin tmp_reg <= mul_rsp.product; state_reg <= S_T2; end
                S_T2:
                begin
                    if (mul_done)
                    begin
                        if (mul_rsp.product <= c2_reg)
                            lo_reg <= mid;
                        else
                            hi_reg <= mid - 16'd1;
                        state_reg <= S_SEARCH;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        corr_reg      <= $signed(score_reg);
                        used_reg      <= job_reg.n;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
